### design/multichannel_sample_mixer_assert.svh
// Assertion macros for the sample mixer checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef MULTICHANNEL_SAMPLE_MIXER_ASSERT_SVH
`define MULTICHANNEL_SAMPLE_MIXER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/msm_pkg.sv
// Shared types and constants for the multichannel sample mixer.
// Used by the top level and by its port checker; depends on nothing.
package msm_pkg;

    localparam int VOICES_DEF           = 8;
    localparam int SAMPLE_ADDR_BITS_DEF = 16;

    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_GAIN  = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_MIX   = 3'd4;

    localparam logic CFG_OUTPUT_RATE = 1'b0;
    localparam logic CFG_VOICE_COUNT = 1'b1;

    localparam logic [16:0] OUTPUT_RATE_RST = 17'd11025;
    localparam logic [3:0]  VOICE_COUNT_RST = 4'd8;
    localparam logic [23:0] STEP_MAX        = 24'hFFFFFF;
    // ceil(2^18 / 3): exact x/3 for x below 2^17
    localparam logic signed [17:0] RECIP3   = 18'sd87382;
    localparam logic signed [25:0] BIAS     = 26'sh800000;

    typedef struct packed {
        logic [2:0]         action;
        logic [2:0]         voice;
        logic [15:0]        address;
        logic [7:0]         byte_value;
        logic [15:0]        length;
        logic [6:0]         volume;
        logic [7:0]         separation;
        logic signed [15:0] mix_in_left;
        logic signed [15:0] mix_in_right;
    } t_item;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic [7:0]         active_mask;
        logic               status;
    } t_result;

endpackage

### design/multichannel_sample_mixer.sv
// Multichannel sample mixer top level: sample memory, voice table, sequencer,
// one shared multiplier and a restoring divider. Depends on msm_pkg.
//
// An item is taken when start is high and busy is low; its one result shows
// on o_result for a single cycle with o_done, and the receiver cannot stall
// it. A valid start or set gains item computes the voice step with the
// 32-step restoring divider unless the output rate is zero. A mix item walks
// the voices in turn through the single multiplier that every product of a
// voice goes through. The sample memory has no reset.
module multichannel_sample_mixer #(
    parameter int VOICES           = msm_pkg::VOICES_DEF,
    parameter int SAMPLE_ADDR_BITS = msm_pkg::SAMPLE_ADDR_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  msm_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_done,
    output msm_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [16:0]      i_cfg_data
);

    localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW        = $clog2(VOICES + 1);
    localparam int MEM_DEPTH = 1 << SAMPLE_ADDR_BITS;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RA   = 5'd1;
    localparam logic [4:0] ST_RB   = 5'd2;
    localparam logic [4:0] ST_RC   = 5'd3;
    localparam logic [4:0] ST_G1   = 5'd4;
    localparam logic [4:0] ST_G2   = 5'd5;
    localparam logic [4:0] ST_G3   = 5'd6;
    localparam logic [4:0] ST_G4   = 5'd7;
    localparam logic [4:0] ST_G5   = 5'd8;
    localparam logic [4:0] ST_DIV  = 5'd9;
    localparam logic [4:0] ST_STEP = 5'd10;
    localparam logic [4:0] ST_MCHK = 5'd11;
    localparam logic [4:0] ST_MA0  = 5'd12;
    localparam logic [4:0] ST_MA1  = 5'd13;
    localparam logic [4:0] ST_MA2  = 5'd14;
    localparam logic [4:0] ST_MS   = 5'd15;
    localparam logic [4:0] ST_MGL  = 5'd16;
    localparam logic [4:0] ST_MQL  = 5'd17;
    localparam logic [4:0] ST_MAL  = 5'd18;
    localparam logic [4:0] ST_MQR  = 5'd19;
    localparam logic [4:0] ST_MAR  = 5'd20;
    localparam logic [4:0] ST_FIN  = 5'd21;

    function automatic logic [SAMPLE_ADDR_BITS-1:0] to_maddr(input logic [17:0] x);
        logic [23:0] w;
        w = 24'(x);
        return w[SAMPLE_ADDR_BITS-1:0];
    endfunction

    // storage
    logic [7:0]  r_mem [MEM_DEPTH];
    logic [7:0]  r_rdata;
    logic [17:0] r_pos    [VOICES];
    logic [16:0] r_end    [VOICES];
    logic [15:0] r_frac   [VOICES];
    logic [23:0] r_step   [VOICES];
    logic [15:0] r_rate   [VOICES];
    logic [6:0]  r_lgain  [VOICES];
    logic [6:0]  r_rgain  [VOICES];
    logic [VOICES-1:0] r_active;

    // control and datapath
    logic [4:0]          r_state;
    msm_pkg::t_item      r_item;
    logic [VW-1:0]       r_cur;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_nvoc;
    logic [7:0]          r_a;
    logic [7:0]          r_lo;
    logic signed [24:0]  r_s;
    logic signed [43:0]  r_prod;
    logic                r_neg;
    logic signed [23:0]  r_acc_l;
    logic signed [23:0]  r_acc_r;
    logic [31:0]         r_dvd;
    logic [16:0]         r_rem;
    logic [4:0]          r_dcnt;
    logic [16:0]         r_orate;
    logic [3:0]          r_vcount;
    logic                r_status;

    logic                        accept;
    logic                        in_range;
    logic [VW-1:0]               vi;
    logic                        mem_we;
    logic [SAMPLE_ADDR_BITS-1:0] mem_waddr;
    logic [SAMPLE_ADDR_BITS-1:0] mem_raddr;
    logic signed [25:0]          mul_a;
    logic signed [17:0]          mul_b;
    logic signed [43:0]          mul_p;
    logic signed [43:0]          prod_abs;
    logic signed [25:0]          s_sum;
    logic [17:0]                 div_trial;
    logic [8:0]                  d_left;
    logic [8:0]                  d_right;
    logic [7:0]                  cut;
    logic [6:0]                  gain_new;
    logic [24:0]                 adv_f;
    logic [17:0]                 adv_pos;
    logic signed [23:0]          term;
    logic [7:0]                  mask;

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign in_range = (32'(i_item.voice) < VOICES);
    assign vi       = (r_item.action == msm_pkg::ACT_MIX) ? r_idx[VW-1:0] : r_cur;
    assign d_left   = 9'(r_item.separation) + 9'd1;
    assign d_right  = 9'd256 - 9'(r_item.separation);

    // cut = (vol * d * d) >> 16, never above 127
    assign cut      = r_prod[23:16];
    assign gain_new = (cut >= {1'b0, r_item.volume}) ? 7'd0
                    : 7'({1'b0, r_item.volume} - cut);

    assign prod_abs  = r_prod[43] ? -r_prod : r_prod;
    assign s_sum     = $signed({2'b00, r_a, 16'h0000}) + r_prod[25:0] - msm_pkg::BIAS;
    assign div_trial = {r_rem, r_dvd[31]};
    assign adv_f     = {9'd0, r_frac[vi]} + {1'b0, r_step[vi]};
    assign adv_pos   = r_pos[vi] + 18'(adv_f[24:16]);
    assign term      = r_neg ? -$signed({8'd0, r_prod[33:18]})
                             :  $signed({8'd0, r_prod[33:18]});

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            mask[i] = (i < VOICES) ? r_active[i] : 1'b0;
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state) inside
            ST_G1: begin
                mul_a = 26'(d_left);
                mul_b = 18'(d_left);
            end
            ST_G3: begin
                mul_a = 26'(d_right);
                mul_b = 18'(d_right);
            end
            ST_G2, ST_G4: begin
                mul_a = 26'(r_prod[16:0]);
                mul_b = 18'(r_item.volume);
            end
            ST_MA2: begin
                mul_a = 26'($signed({1'b0, r_rdata}) - $signed({1'b0, r_a}));
                mul_b = 18'(r_frac[vi]);
            end
            ST_MGL: begin
                mul_a = 26'(r_s);
                mul_b = 18'(r_lgain[vi]);
            end
            ST_MAL: begin
                mul_a = 26'(r_s);
                mul_b = 18'(r_rgain[vi]);
            end
            ST_MQL, ST_MQR: begin
                mul_a = 26'(prod_abs[30:14]);
                mul_b = msm_pkg::RECIP3;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // memory ports
    assign mem_we    = accept && (i_item.action == msm_pkg::ACT_LOAD);
    assign mem_waddr = to_maddr(18'(i_item.address));
    always_comb begin
        unique case (r_state)
            ST_RA:   mem_raddr = to_maddr(18'(r_item.address) + 18'd2);
            ST_RB:   mem_raddr = to_maddr(18'(r_item.address) + 18'd3);
            ST_MA1:  mem_raddr = to_maddr(r_pos[vi] + 18'd1);
            default: mem_raddr = to_maddr(r_pos[vi]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_item.byte_value;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orate  <= msm_pkg::OUTPUT_RATE_RST;
            r_vcount <= msm_pkg::VOICE_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msm_pkg::CFG_OUTPUT_RATE: r_orate  <= i_cfg_data;
                default:                  r_vcount <= i_cfg_data[3:0];
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            o_done   <= 1'b0;
            r_active <= '0;
            for (int i = 0; i < VOICES; i++) begin
                r_pos[i]   <= '0;
                r_end[i]   <= '0;
                r_frac[i]  <= '0;
                r_step[i]  <= '0;
                r_rate[i]  <= '0;
                r_lgain[i] <= '0;
                r_rgain[i] <= '0;
            end
        end else begin
            o_done <= 1'b0;
            unique case (r_state) inside
                ST_IDLE: begin
                    if (accept) begin
                        r_item   <= i_item;
                        r_cur    <= VW'(i_item.voice);
                        r_status <= 1'b0;
                        r_idx    <= '0;
                        r_nvoc   <= (32'(r_vcount) > VOICES) ? CW'(VOICES) : CW'(r_vcount);
                        r_acc_l  <= 24'(i_item.mix_in_left);
                        r_acc_r  <= 24'(i_item.mix_in_right);
                        r_state  <= ST_FIN;
                        case (i_item.action)
                            msm_pkg::ACT_START: begin
                                if (i_item.length <= 16'd8) begin
                                    r_status <= 1'b1;
                                end else if (in_range) begin
                                    r_state <= ST_RA;
                                end
                            end
                            msm_pkg::ACT_GAIN: begin
                                if (in_range) begin
                                    r_state <= ST_G1;
                                end
                            end
                            msm_pkg::ACT_STOP: begin
                                if (in_range) begin
                                    r_active[VW'(i_item.voice)] <= 1'b0;
                                end
                            end
                            msm_pkg::ACT_MIX: r_state <= ST_MCHK;
                            default:          r_state <= ST_FIN;
                        endcase
                    end
                end
                ST_RA: r_state <= ST_RB;
                ST_RB: begin
                    r_lo    <= r_rdata;
                    r_state <= ST_RC;
                end
                ST_RC: begin
                    r_rate[r_cur]   <= {r_rdata, r_lo};
                    r_pos[r_cur]    <= 18'(r_item.address) + 18'd8;
                    r_end[r_cur]    <= 17'(17'(r_item.address) + 17'(r_item.length) - 17'd9);
                    r_frac[r_cur]   <= '0;
                    r_active[r_cur] <= 1'b1;
                    r_state         <= ST_G1;
                end
                ST_G1: begin
                    r_prod  <= mul_p;
                    r_state <= ST_G2;
                end
                ST_G2: begin
                    r_prod  <= mul_p;
                    r_state <= ST_G3;
                end
                ST_G3: begin
                    r_lgain[r_cur] <= gain_new;
                    r_prod         <= mul_p;
                    r_state        <= ST_G4;
                end
                ST_G4: begin
                    r_prod  <= mul_p;
                    r_state <= ST_G5;
                end
                ST_G5: begin
                    r_rgain[r_cur] <= gain_new;
                    if (r_orate == '0) begin
                        r_step[r_cur] <= msm_pkg::STEP_MAX;
                        r_state       <= ST_FIN;
                    end else begin
                        r_dvd   <= {r_rate[r_cur], 16'h0000};
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // one quotient bit per cycle, shifted into the dividend
                    if (div_trial >= {1'b0, r_orate}) begin
                        r_rem <= 17'(div_trial - {1'b0, r_orate});
                        r_dvd <= {r_dvd[30:0], 1'b1};
                    end else begin
                        r_rem <= div_trial[16:0];
                        r_dvd <= {r_dvd[30:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_state <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    r_step[r_cur] <= (|r_dvd[31:24]) ? msm_pkg::STEP_MAX : r_dvd[23:0];
                    r_state       <= ST_FIN;
                end
                ST_MCHK: begin
                    if (r_idx >= r_nvoc) begin
                        r_state <= ST_FIN;
                    end else if (!r_active[vi]) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_state <= ST_MA0;
                    end
                end
                ST_MA0: r_state <= ST_MA1;
                ST_MA1: begin
                    r_a     <= r_rdata;
                    r_state <= ST_MA2;
                end
                ST_MA2: begin
                    r_prod  <= mul_p;
                    r_state <= ST_MS;
                end
                ST_MS: begin
                    r_s     <= s_sum[24:0];
                    r_state <= ST_MGL;
                end
                ST_MGL: begin
                    r_prod  <= mul_p;
                    r_state <= ST_MQL;
                end
                ST_MQL, ST_MQR: begin
                    r_neg   <= r_prod[43];
                    r_prod  <= mul_p;
                    r_state <= (r_state == ST_MQL) ? ST_MAL : ST_MAR;
                end
                ST_MAL: begin
                    r_acc_l <= r_acc_l + term;
                    r_prod  <= mul_p;
                    r_state <= ST_MQR;
                end
                ST_MAR: begin
                    r_acc_r    <= r_acc_r + term;
                    r_pos[vi]  <= adv_pos;
                    r_frac[vi] <= adv_f[15:0];
                    if (adv_pos >= {1'b0, r_end[vi]}) begin
                        r_active[vi] <= 1'b0;
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= ST_MCHK;
                end
                ST_FIN: begin
                    o_done               <= 1'b1;
                    o_result.active_mask <= mask;
                    o_result.status      <= r_status;
                    if (r_item.action == msm_pkg::ACT_MIX) begin
                        o_result.left_out  <= (r_acc_l > 24'sd32767) ? 16'sh7FFF
                                            : (r_acc_l < -24'sd32768) ? 16'sh8000
                                            : r_acc_l[15:0];
                        o_result.right_out <= (r_acc_r > 24'sd32767) ? 16'sh7FFF
                                            : (r_acc_r < -24'sd32768) ? 16'sh8000
                                            : r_acc_r[15:0];
                    end else begin
                        o_result.left_out  <= '0;
                        o_result.right_out <= '0;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### design/msm_checker.sv
// Port-level checker for the multichannel sample mixer, bound to the top.
// Depends on msm_pkg and multichannel_sample_mixer_assert.svh.
`include "multichannel_sample_mixer_assert.svh"

module msm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input msm_pkg::t_result o_result,
    input logic             i_cfg_we
);

    `MSM_ASSERT_NEXT(a_take_goes_busy, start && !busy, busy, "item taken but block not busy")
    `MSM_ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe longer than one cycle")
    `MSM_ASSERT_NOW(a_done_frees, o_done, !busy, "block still busy with its result")
    `MSM_ASSERT_NOW(a_reject_silent, o_done && o_result.status, o_result.left_out == 16'sd0 && o_result.right_out == 16'sd0, "rejected start carries mix data")
    `MSM_ASSERT_NOW(a_cfg_idle, i_cfg_we, !busy, "register write while an item is in flight")

endmodule

bind multichannel_sample_mixer msm_checker u_msm_checker (.*);

### tb/tb_top.sv
// Self-checking bench for multichannel_sample_mixer: drives load, start, gain,
// stop and mix items, predicts every result in a scoreboard. Depends on msm_pkg.
module tb_top;
    import msm_pkg::*;

    localparam int NVOICE = 8;
    localparam int WATCHDOG = 20000;

    class mixer_scoreboard;
        logic [7:0]  mem [int];
        logic [16:0] out_rate;
        logic [3:0]  walk_count;
        logic [17:0] pos [NVOICE];
        logic [16:0] stop_at [NVOICE];
        logic [15:0] frac [NVOICE];
        logic [23:0] stp [NVOICE];
        logic [15:0] rate [NVOICE];
        logic [6:0]  lgain [NVOICE];
        logic [6:0]  rgain [NVOICE];
        bit          playing [NVOICE];
        t_result     pending [$];
        int          errors;

        function void clear();
            out_rate = OUTPUT_RATE_RST;
            walk_count = VOICE_COUNT_RST;
            for (int v = 0; v < NVOICE; v++) begin
                pos[v] = 0; stop_at[v] = 0; frac[v] = 0; stp[v] = 0; rate[v] = 0;
                lgain[v] = 0; rgain[v] = 0; playing[v] = 0;
            end
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [16:0] val);
            if (idx == CFG_OUTPUT_RATE) out_rate = val;
            else walk_count = val[3:0];
        endfunction

        function logic [7:0] peek(longint a);
            int k;
            k = int'(a & 64'hFFFF);
            return mem.exists(k) ? mem[k] : 8'd0;
        endfunction

        function logic [6:0] square_gain(longint vol, longint d);
            longint cut;
            cut = (vol * d * d) >>> 16;
            if (cut >= vol) return 0;
            return (vol - cut > 127) ? 7'd127 : 7'(vol - cut);
        endfunction

        function void set_gains(int v, logic [6:0] vol, logic [7:0] sep);
            longint q, s;
            s = longint'(sep) + 1;
            if (out_rate == 0) q = STEP_MAX;
            else begin
                q = (longint'(rate[v]) << 16) / longint'(out_rate);
                if (q > 64'hFFFFFF) q = STEP_MAX;
            end
            stp[v] = 24'(q);
            lgain[v] = square_gain(vol, s);
            rgain[v] = square_gain(vol, 257 - s);
        endfunction

        function void note_item(t_item it);
            t_result r;
            longint dl, dr, smp, a, b, f, n;
            int v;
            r = '0;
            dl = 0; dr = 0;
            v = it.voice;
            case (it.action)
                ACT_LOAD: mem[int'(it.address)] = it.byte_value;
                ACT_START: begin
                    if (it.length <= 8) r.status = 1;
                    else begin
                        pos[v] = 18'(longint'(it.address) + 8);
                        stop_at[v] = 17'(longint'(it.address) + it.length - 9);
                        rate[v] = {peek(longint'(it.address) + 3),
                                   peek(longint'(it.address) + 2)};
                        frac[v] = 0;
                        playing[v] = 1;
                        set_gains(v, it.volume, it.separation);
                    end
                end
                ACT_GAIN: set_gains(v, it.volume, it.separation);
                ACT_STOP: playing[v] = 0;
                ACT_MIX: begin
                    dl = it.mix_in_left;
                    dr = it.mix_in_right;
                    n = walk_count > NVOICE ? NVOICE : walk_count;
                    for (int i = 0; i < n; i++) begin
                        if (!playing[i]) continue;
                        f = frac[i];
                        a = peek(pos[i]);
                        b = peek(longint'(pos[i]) + 1);
                        smp = a * (65536 - f) + b * f - 64'h800000;
                        // SV division truncates toward zero, as required
                        dl += (longint'(lgain[i]) * smp) / 49152;
                        dr += (longint'(rgain[i]) * smp) / 49152;
                        f += stp[i];
                        pos[i] = 18'(longint'(pos[i]) + (f >> 16));
                        frac[i] = 16'(f);
                        if (pos[i] >= stop_at[i]) playing[i] = 0;
                    end
                    dl = dl > 32767 ? 32767 : (dl < -32768 ? -32768 : dl);
                    dr = dr > 32767 ? 32767 : (dr < -32768 ? -32768 : dr);
                end
                default: ;
            endcase
            r.left_out = 16'(dl);
            r.right_out = 16'(dr);
            for (int i = 0; i < NVOICE; i++) r.active_mask[i] = playing[i];
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result w;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.left_out !== w.left_out) begin
                $error("left_out expected %0d actual %0d", w.left_out, got.left_out);
                errors++;
            end
            if (got.right_out !== w.right_out) begin
                $error("right_out expected %0d actual %0d", w.right_out, got.right_out);
                errors++;
            end
            if (got.active_mask !== w.active_mask) begin
                $error("active_mask expected %h actual %h", w.active_mask, got.active_mask);
                errors++;
            end
            if (got.status !== w.status) begin
                $error("status expected %b actual %b", w.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    t_item       i_item = '0;
    logic        busy, o_done;
    t_result     o_result;
    logic        i_cfg_we = 0;
    logic        i_cfg_index = 0;
    logic [16:0] i_cfg_data = 0;

    mixer_scoreboard board;
    int  quiet_cycles = 0;
    bit  calm = 0;
    bit  written [int];
    int  sound_base [4];
    int  sound_len [4];

    always #5 i_clk = ~i_clk;

    multichannel_sample_mixer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_result(o_result);
        if ((start && !busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Hold start high from item to item; drop it only for an idle burst.
    task automatic send(t_item it);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(it);
        // avoid read of unwritten bytes later
        if (it.action == ACT_LOAD) written[int'(it.address)] = 1;
    endtask

    task automatic drain();
        start <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [16:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    function automatic t_item noise();
        t_item it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(t_item)-1:0];
        return it;
    endfunction

    task automatic load(int a, logic [7:0] val);
        t_item it;
        it = noise();
        it.action = ACT_LOAD;
        it.address = 16'(a);
        it.byte_value = val;
        send(it);
    endtask

    // Load a whole sound: header with rate, then body; pad one byte past end.
    task automatic load_sound(int slot, int base, int len, logic [15:0] hz);
        for (int k = 0; k < len + 1; k++) begin
            if (k == 2) load(base + k, hz[7:0]);
            else if (k == 3) load(base + k, hz[15:8]);
            else load(base + k, 8'($urandom));
        end
        sound_base[slot] = base;
        sound_len[slot] = len;
    endtask

    function automatic t_item voice_op(logic [2:0] act, int v, int slot);
        t_item it;
        it = noise();
        it.action = act;
        it.voice = 3'(v);
        it.address = 16'(sound_base[slot]);
        it.length = 16'(sound_len[slot]);
        return it;
    endfunction

    function automatic t_item mix_item();
        t_item it;
        it = noise();
        it.action = ACT_MIX;
        return it;
    endfunction

    function automatic bit safe_start(t_item it);
        longint top;
        // a start reads header bytes and plays bytes 8 and 9 at least
        if (it.length <= 8) return 1;
        top = longint'(it.length) - 8;
        if (top < 9) top = 9;
        for (int k = 2; k < 4; k++)
            if (!written.exists(int'((it.address + k) & 16'hFFFF))) return 0;
        for (longint k = 8; k <= top; k++)
            if (!written.exists(int'((it.address + k) & 16'hFFFF))) return 0;
        return 1;
    endfunction

    initial begin
        t_item it;
        int sent, r;
        board = new();
        board.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        load_sound(0, 0, 24, 16'd11025);
        load_sound(1, 16'hFFE0, 20, 16'hFFFF);
        load_sound(2, 100, 12, 16'd0);
        load_sound(3, 300, 40, 16'd22050);
        it = voice_op(ACT_START, 0, 0); it.volume = 127; it.separation = 0; send(it);
        it = voice_op(ACT_START, 1, 1); it.volume = 127; it.separation = 255; send(it);
        it = voice_op(ACT_START, 7, 3); it.volume = 0; send(it);
        it = voice_op(ACT_START, 2, 0); it.length = 8; send(it);
        it = voice_op(ACT_START, 2, 0); it.length = 0; send(it);
        it = voice_op(ACT_GAIN, 5, 0); it.volume = 127; it.separation = 128; send(it);
        it = mix_item(); it.mix_in_left = 16'sh7FFF; it.mix_in_right = -16'sh8000; send(it);
        it = mix_item(); it.mix_in_left = -16'sh8000; it.mix_in_right = 16'sh7FFF; send(it);
        it = voice_op(ACT_STOP, 7, 0); send(it);
        it = noise(); it.action = 3'd5; send(it);
        it = noise(); it.action = 3'd7; send(it);
        for (int k = 0; k < 6; k++) send(mix_item());

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin write_cfg(CFG_OUTPUT_RATE, 17'd4000); write_cfg(CFG_VOICE_COUNT, 4'd1); end
                1: begin write_cfg(CFG_OUTPUT_RATE, 17'd96000); write_cfg(CFG_VOICE_COUNT, 4'd15); end
                2: begin write_cfg(CFG_OUTPUT_RATE, 17'd0); write_cfg(CFG_VOICE_COUNT, 4'd0); end
                3: begin write_cfg(CFG_OUTPUT_RATE, 17'h1FFFF); write_cfg(CFG_VOICE_COUNT, 4'd8); end
                4: begin write_cfg(CFG_OUTPUT_RATE, 17'd1); write_cfg(CFG_VOICE_COUNT, 4'd4); end
                default: begin
                    write_cfg(CFG_OUTPUT_RATE, 17'($urandom_range(4000, 96000)));
                    write_cfg(CFG_VOICE_COUNT, 4'd8);
                    calm = 1;
                end
            endcase
            if (phase == 2) begin
                load_sound(2, $urandom_range(1000, 60000), $urandom_range(9, 30), 16'($urandom));
            end
            sent = 0;
            while (sent < 130) begin
                r = $urandom_range(0, 99);
                if (r < 55) it = mix_item();
                else if (r < 72) begin
                    it = voice_op(ACT_START, $urandom_range(0, 7), $urandom_range(0, 3));
                    if ($urandom_range(0, 9) == 0) it.length = 16'($urandom_range(0, 8));
                end else if (r < 82) it = voice_op(ACT_GAIN, $urandom_range(0, 7), 0);
                else if (r < 88) it = voice_op(ACT_STOP, $urandom_range(0, 7), 0);
                else if (r < 92) begin
                    it = noise();
                    it.action = 3'($urandom_range(5, 7));
                end else if (r < 96) begin
                    it = noise();
                    if (it.action == ACT_START && !safe_start(it)) it.length = 16'd8;
                    if (it.action == ACT_MIX) it.action = ACT_GAIN;
                end else begin
                    it = noise();
                    it.action = ACT_LOAD;
                    // keep the directed sounds intact
                    it.address = 16'($urandom_range(30000, 40000));
                end
                send(it);
                sent++;
                if (sent == 65 && phase == 1) drain();
            end
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0) $display("tb_top: clean");
        else $display("tb_top: errors");
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/msm_pkg.sv
design/multichannel_sample_mixer.sv
design/msm_checker.sv
tb/tb_top.sv
